/* hw/rtl/wams_pkg.sv */
// shared types and codes of the weighted adjacency matrix store
package wams_pkg;

    localparam int VERTEX_W = 5;
    localparam int WEIGHT_W = 16;
    localparam int DEG_W    = 5;
    localparam int TOTAL_W  = 6;
    localparam int COUNT_W  = 5;

    // operation codes
    localparam logic [2:0] OP_ADD_EDGE    = 3'd0;
    localparam logic [2:0] OP_REMOVE_EDGE = 3'd1;
    localparam logic [2:0] OP_DEGREE      = 3'd2;
    localparam logic [2:0] OP_ALL_DEGREES = 3'd3;
    localparam logic [2:0] OP_ADJ_LIST    = 3'd4;
    localparam logic [2:0] OP_EDGE_TEST   = 3'd5;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_PRESENT = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;
    localparam logic [1:0] ST_NONE    = 2'd3;

    typedef struct packed {
        logic signed [WEIGHT_W-1:0] edge_weight;
        logic [VERTEX_W-1:0]        to_vertex;
        logic [VERTEX_W-1:0]        from_vertex;
        logic [2:0]                 operation;
    } item_t;

    typedef struct packed {
        logic                last_result;
        logic                edge_present;
        logic [TOTAL_W-1:0]  total_degree;
        logic [DEG_W-1:0]    out_degree;
        logic [DEG_W-1:0]    in_degree;
        logic [VERTEX_W-1:0] vertex_number;
        logic [1:0]          status;
    } result_t;

    typedef struct packed {
        logic clearing;
        logic scanning;
    } ctrl_status_t;

endpackage

/* hw/rtl/weighted_adjacency_matrix_store.sv */
// top level of the weighted adjacency matrix store
// Directed weighted graph held as a MAX_VERTICES x MAX_VERTICES matrix of signed
// 16-bit weights in one synchronous memory with two read ports; a zero weight means
// no edge, and every vertex number on the ports is 1-based. After reset the block
// runs a clearing pass that writes zero into all 2^(2*ceil(log2(MAX_VERTICES)))
// cells, one a cycle, and accepts no request until it ends; vertex_count writes are
// taken at any time. One request is worked on at a time. Add, remove and edge test
// pass through accept, decode, cell read and result, the memory read latency
// setting the pace. A vertex degree reads one row cell and one column cell per
// cycle through the two read ports over the n vertices in use. All degrees
// repeats that scan for each vertex, and an adjacent list reads the row. Output
// backpressure stalls the scan only when a result cannot be handed over; results
// wait in an output register so the next request can already be taken while the
// last result is still pending.
module weighted_adjacency_matrix_store #(
    parameter int MAX_VERTICES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // operation[2:0], from_vertex[7:3], to_vertex[12:8],
                                    // edge_weight[28:13] signed, zeros above
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // status[1:0], vertex_number[6:2], in_degree[11:7],
                                    // out_degree[16:12], total_degree[22:17],
                                    // edge_present[23]
    output logic        m_tlast,    // last result of the request
    // vertex_count register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data
);
    import wams_pkg::*;

    localparam int IDX_W  = $clog2(MAX_VERTICES);
    localparam int ADDR_W = 2 * IDX_W;

    logic [COUNT_W-1:0]  vertex_count_reg;
    logic                out_valid_reg;
    result_t             out_data_reg;

    item_t               item;
    logic                res_valid;
    logic                res_ready;
    result_t             res;
    ctrl_status_t        ctrl_status;

    logic                mem_wr_en;
    logic [ADDR_W-1:0]   mem_wr_addr;
    logic [WEIGHT_W-1:0] mem_wr_data;
    logic                mem_rd_en;
    logic [ADDR_W-1:0]   mem_rd_addr_a;
    logic [ADDR_W-1:0]   mem_rd_addr_b;
    logic [WEIGHT_W-1:0] mem_rd_data_a;
    logic [WEIGHT_W-1:0] mem_rd_data_b;

    // request unpacking
    assign item.operation   = s_tdata[2:0];
    assign item.from_vertex = s_tdata[7:3];
    assign item.to_vertex   = s_tdata[12:8];
    assign item.edge_weight = s_tdata[28:13];

    // vertex count register, reset to 16, a full matrix at the default size
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= COUNT_W'(16);
        end
        else if (cfg_valid && cfg_ready)
        begin
            vertex_count_reg <= cfg_data;
        end
    end

    wams_ctrl #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .vertex_count  (vertex_count_reg),
        .item_valid    (s_tvalid),
        .item_ready    (s_tready),
        .item          (item),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .status        (ctrl_status),
        .mem_wr_en     (mem_wr_en),
        .mem_wr_addr   (mem_wr_addr),
        .mem_wr_data   (mem_wr_data),
        .mem_rd_en     (mem_rd_en),
        .mem_rd_addr_a (mem_rd_addr_a),
        .mem_rd_addr_b (mem_rd_addr_b),
        .mem_rd_data_a (mem_rd_data_a),
        .mem_rd_data_b (mem_rd_data_b)
    );

    wams_matrix_mem #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_matrix_mem (
        .clk       (clk),
        .wr_en     (mem_wr_en),
        .wr_addr   (mem_wr_addr),
        .wr_data   (mem_wr_data),
        .rd_en     (mem_rd_en),
        .rd_addr_a (mem_rd_addr_a),
        .rd_addr_b (mem_rd_addr_b),
        .rd_data_a (mem_rd_data_a),
        .rd_data_b (mem_rd_data_b)
    );

    // output register: takes a new result when empty or being drained
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg.edge_present, out_data_reg.total_degree,
                       out_data_reg.out_degree, out_data_reg.in_degree,
                       out_data_reg.vertex_number, out_data_reg.status};
    assign m_tlast  = out_data_reg.last_result;

`ifndef NO_ASSERTIONS
    // no request is taken while the matrix is still being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_status.clearing |-> !s_tready)
        else $error("request accepted during clearing pass");

    // a request occupies the sequencer for at least the following cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (!s_tready && !ctrl_status.clearing))
        else $error("sequencer ready right after accepting a request");

    // no request is taken while a row or column scan is running
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_status.scanning |-> !s_tready)
        else $error("request accepted during a scan");

    // total degree always matches its parts
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_data_reg.total_degree
                      == TOTAL_W'(out_data_reg.in_degree) + TOTAL_W'(out_data_reg.out_degree)))
        else $error("total degree mismatch");
`endif

endmodule

/* hw/rtl/wams_matrix_mem.sv */
// weight matrix memory, one write port, two registered read ports
module wams_matrix_mem #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [2*$clog2(MAX_VERTICES)-1:0]         wr_addr,
    input  logic [wams_pkg::WEIGHT_W-1:0]             wr_data,
    input  logic                                      rd_en,
    input  logic [2*$clog2(MAX_VERTICES)-1:0]         rd_addr_a,
    input  logic [2*$clog2(MAX_VERTICES)-1:0]         rd_addr_b,
    output logic [wams_pkg::WEIGHT_W-1:0]             rd_data_a,
    output logic [wams_pkg::WEIGHT_W-1:0]             rd_data_b
);
    import wams_pkg::*;

    localparam int IDX_W  = $clog2(MAX_VERTICES);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH  = 1 << ADDR_W;

    logic [WEIGHT_W-1:0] matrix_reg [DEPTH];
    logic [WEIGHT_W-1:0] rd_data_a_reg;
    logic [WEIGHT_W-1:0] rd_data_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            matrix_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a_reg <= matrix_reg[rd_addr_a];
            rd_data_b_reg <= matrix_reg[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

/* hw/rtl/wams_ctrl.sv */
// operation sequencer: decode, cell read-modify-write, row and column scans
module wams_ctrl #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [wams_pkg::COUNT_W-1:0]          vertex_count,
    input  logic                                  item_valid,
    output logic                                  item_ready,
    input  wams_pkg::item_t                       item,
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output wams_pkg::result_t                     res,
    output wams_pkg::ctrl_status_t                status,
    output logic                                  mem_wr_en,
    output logic [2*$clog2(MAX_VERTICES)-1:0]     mem_wr_addr,
    output logic [wams_pkg::WEIGHT_W-1:0]         mem_wr_data,
    output logic                                  mem_rd_en,
    output logic [2*$clog2(MAX_VERTICES)-1:0]     mem_rd_addr_a,
    output logic [2*$clog2(MAX_VERTICES)-1:0]     mem_rd_addr_b,
    input  logic [wams_pkg::WEIGHT_W-1:0]         mem_rd_data_a,
    input  logic [wams_pkg::WEIGHT_W-1:0]         mem_rd_data_b
);
    import wams_pkg::*;

    localparam int IDX_W  = $clog2(MAX_VERTICES);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int N_W    = $clog2(MAX_VERTICES + 1);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_DECODE = 7'b0000100,
        S_CELL   = 7'b0001000,
        S_SCAN   = 7'b0010000,
        S_LIST   = 7'b0100000,
        S_EMIT   = 7'b1000000
    } state_t;

    state_t              state_reg,      state_next;
    item_t               item_reg,       item_next;
    result_t             res_reg,        res_next;
    logic [ADDR_W-1:0]   clr_addr_reg,   clr_addr_next;
    logic [N_W-1:0]      idx_reg,        idx_next;
    logic                pend_reg,       pend_next;
    logic [IDX_W-1:0]    pend_idx_reg,   pend_idx_next;
    logic [IDX_W-1:0]    v_reg,          v_next;
    logic [DEG_W-1:0]    in_cnt_reg,     in_cnt_next;
    logic [DEG_W-1:0]    out_cnt_reg,    out_cnt_next;
    logic                hold_valid_reg, hold_valid_next;
    logic [VERTEX_W-1:0] hold_vnum_reg,  hold_vnum_next;

    logic [N_W-1:0]      n_eff;
    logic                fv_ok;
    logic                tv_ok;
    logic [IDX_W-1:0]    fv_idx;
    logic [IDX_W-1:0]    tv_idx;
    logic [IDX_W-1:0]    scan_idx;
    logic                issue;
    logic                nz_a;
    logic                nz_b;
    logic                emit_now;
    logic                stall;
    result_t             r;

    // vertex count saturates at the matrix size
    always_comb
    begin
        if (32'(vertex_count) > 32'(MAX_VERTICES))
        begin
            n_eff = N_W'(MAX_VERTICES);
        end
        else
        begin
            n_eff = N_W'(vertex_count);
        end
    end

    assign fv_ok    = (item_reg.from_vertex != '0) && (32'(item_reg.from_vertex) <= 32'(n_eff));
    assign tv_ok    = (item_reg.to_vertex != '0) && (32'(item_reg.to_vertex) <= 32'(n_eff));
    assign fv_idx   = IDX_W'(item_reg.from_vertex - VERTEX_W'(1));
    assign tv_idx   = IDX_W'(item_reg.to_vertex - VERTEX_W'(1));
    assign scan_idx = idx_reg[IDX_W-1:0];
    assign issue    = (32'(idx_reg) < 32'(n_eff));
    assign nz_a     = (mem_rd_data_a != '0);
    assign nz_b     = (mem_rd_data_b != '0);

    // a found neighbor goes out only once the next one proves it is not the last
    assign emit_now = (state_reg == S_LIST) && pend_reg && nz_a && hold_valid_reg;
    assign stall    = emit_now && !res_ready;

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        res_next        = res_reg;
        clr_addr_next   = clr_addr_reg;
        idx_next        = idx_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        v_next          = v_reg;
        in_cnt_next     = in_cnt_reg;
        out_cnt_next    = out_cnt_reg;
        hold_valid_next = hold_valid_reg;
        hold_vnum_next  = hold_vnum_reg;

        item_ready    = 1'b0;
        res_valid     = 1'b0;
        res           = res_reg;
        mem_wr_en     = 1'b0;
        mem_wr_addr   = '0;
        mem_wr_data   = '0;
        mem_rd_en     = 1'b0;
        mem_rd_addr_a = '0;
        mem_rd_addr_b = '0;

        r               = '0;
        r.status        = ST_OK;
        r.vertex_number = item_reg.from_vertex;
        r.last_result   = 1'b1;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_wr_en     = 1'b1;
                mem_wr_addr   = clr_addr_reg;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    item_next  = item;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                idx_next        = '0;
                pend_next       = 1'b0;
                in_cnt_next     = '0;
                out_cnt_next    = '0;
                hold_valid_next = 1'b0;
                priority if (item_reg.operation == OP_ADD_EDGE
                             || item_reg.operation == OP_REMOVE_EDGE
                             || item_reg.operation == OP_EDGE_TEST)
                begin
                    if (fv_ok && tv_ok)
                    begin
                        mem_rd_en     = 1'b1;
                        mem_rd_addr_a = {fv_idx, tv_idx};
                        state_next    = S_CELL;
                    end
                    else
                    begin
                        r.status   = ST_RANGE;
                        res_next   = r;
                        state_next = S_EMIT;
                    end
                end
                else if (item_reg.operation == OP_DEGREE
                         || item_reg.operation == OP_ADJ_LIST)
                begin
                    if (fv_ok)
                    begin
                        v_next = fv_idx;
                        if (item_reg.operation == OP_DEGREE)
                        begin
                            state_next = S_SCAN;
                        end
                        else
                        begin
                            state_next = S_LIST;
                        end
                    end
                    else
                    begin
                        r.status   = ST_RANGE;
                        res_next   = r;
                        state_next = S_EMIT;
                    end
                end
                else if (item_reg.operation == OP_ALL_DEGREES)
                begin
                    if (n_eff == '0)
                    begin
                        r.status        = ST_RANGE;
                        r.vertex_number = '0;
                        res_next        = r;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        v_next     = '0;
                        state_next = S_SCAN;
                    end
                end
                else
                begin
                    // unknown operation, no result
                    state_next = S_IDLE;
                end
            end

            S_CELL:
            begin
                if (item_reg.operation == OP_ADD_EDGE)
                begin
                    if (nz_a)
                    begin
                        r.status = ST_PRESENT;
                    end
                    else
                    begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = {fv_idx, tv_idx};
                        mem_wr_data = item_reg.edge_weight;
                    end
                end
                else if (item_reg.operation == OP_REMOVE_EDGE)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = {fv_idx, tv_idx};
                end
                else
                begin
                    r.edge_present = nz_a;
                end
                res_next   = r;
                state_next = S_EMIT;
            end

            S_SCAN:
            begin
                // port a walks the row, port b the column
                if (pend_reg)
                begin
                    out_cnt_next = out_cnt_reg + DEG_W'(nz_a);
                    in_cnt_next  = in_cnt_reg + DEG_W'(nz_b);
                end
                pend_next = issue;
                if (issue)
                begin
                    mem_rd_en     = 1'b1;
                    mem_rd_addr_a = {v_reg, scan_idx};
                    mem_rd_addr_b = {scan_idx, v_reg};
                    idx_next      = idx_reg + N_W'(1);
                end
                else if (!pend_reg)
                begin
                    r.vertex_number = VERTEX_W'(32'(v_reg) + 32'd1);
                    r.in_degree     = in_cnt_reg;
                    r.out_degree    = out_cnt_reg;
                    r.total_degree  = TOTAL_W'(in_cnt_reg) + TOTAL_W'(out_cnt_reg);
                    r.last_result   = (item_reg.operation == OP_DEGREE)
                                      || (32'(v_reg) + 32'd1 == 32'(n_eff));
                    res_next        = r;
                    state_next      = S_EMIT;
                end
            end

            S_LIST:
            begin
                res_valid           = emit_now;
                res                 = '0;
                res.status          = ST_OK;
                res.vertex_number   = hold_vnum_reg;
                if (!stall)
                begin
                    if (pend_reg && nz_a)
                    begin
                        hold_valid_next = 1'b1;
                        hold_vnum_next  = VERTEX_W'(32'(pend_idx_reg) + 32'd1);
                    end
                    pend_next = issue;
                    if (issue)
                    begin
                        mem_rd_en     = 1'b1;
                        mem_rd_addr_a = {v_reg, scan_idx};
                        pend_idx_next = scan_idx;
                        idx_next      = idx_reg + N_W'(1);
                    end
                    else if (!pend_reg)
                    begin
                        if (hold_valid_reg)
                        begin
                            r.vertex_number = hold_vnum_reg;
                        end
                        else
                        begin
                            r.status = ST_NONE;
                        end
                        res_next   = r;
                        state_next = S_EMIT;
                    end
                end
            end

            S_EMIT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    if (item_reg.operation == OP_ALL_DEGREES && !res_reg.last_result)
                    begin
                        v_next       = v_reg + IDX_W'(1);
                        idx_next     = '0;
                        pend_next    = 1'b0;
                        in_cnt_next  = '0;
                        out_cnt_next = '0;
                        state_next   = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            pend_reg       <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            pend_reg       <= pend_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        res_reg       <= res_next;
        idx_reg       <= idx_next;
        pend_idx_reg  <= pend_idx_next;
        v_reg         <= v_next;
        in_cnt_reg    <= in_cnt_next;
        out_cnt_reg   <= out_cnt_next;
        hold_vnum_reg <= hold_vnum_next;
    end

    assign status.clearing = (state_reg == S_CLEAR);
    assign status.scanning = (state_reg == S_SCAN) || (state_reg == S_LIST);

endmodule

/* verif/tb_top.sv */
// self-checking testbench of the weighted adjacency matrix store
`timescale 1ns / 1ps

module tb_top;

    import wams_pkg::*;

    localparam int MAX_V        = 16;
    // longest request is all degrees at 16 vertices
    localparam int DRAIN_CYCLES = 400;
    localparam int HOLD_CYCLES  = 600;

    // operation codes the block ignores
    localparam logic [2:0] OP_RESERVED_A = 3'd6;
    localparam logic [2:0] OP_RESERVED_B = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data = '0;

    // requests waiting to be offered, and results still owed by the block
    item_t   pending_requests[$];
    result_t expected_results[$];

    // shadow copy of the graph and of the vertex_count register
    logic [15:0] graph_cells [MAX_V][MAX_V] = '{default: 16'h0};
    logic [4:0]  shadow_vertex_count = 5'd16;

    int  mismatches     = 0;
    int  requests_taken = 0;
    bit  req_taken      = 1'b0;
    bit  idling_enabled = 1'b1;
    bit  rx_hold        = 1'b0;
    int  tx_idle_left   = 0;
    int  rx_idle_left   = 0;

    weighted_adjacency_matrix_store #(
        .MAX_VERTICES(MAX_V)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // graph predictor
    // ------------------------------------------------------------------

    // counts above the matrix size saturate
    function automatic int active_vertices();
        return (shadow_vertex_count > MAX_V) ? MAX_V : int'(shadow_vertex_count);
    endfunction

    function automatic bit vertex_in_range(int v, int n);
        return (v >= 1) && (v <= n);
    endfunction

    task automatic push_expected(logic [1:0] st, int vnum, int din, int dout,
                                 bit present, bit last);
        result_t r;
        int      total;
        total           = din + dout;
        r.status        = st;
        r.vertex_number = vnum[4:0];
        r.in_degree     = din[4:0];
        r.out_degree    = dout[4:0];
        r.total_degree  = total[5:0];
        r.edge_present  = present;
        r.last_result   = last;
        expected_results.push_back(r);
    endtask

    // v0 is zero-based; only the first n rows and columns are scanned
    task automatic count_degrees(int v0, int n, output int din, output int dout);
        din  = 0;
        dout = 0;
        for (int i = 0; i < n; i++)
        begin
            if (graph_cells[v0][i] != 16'h0)
                dout++;
            if (graph_cells[i][v0] != 16'h0)
                din++;
        end
    endtask

    task automatic predict_graph_results(item_t req);
        int n;
        int fv;
        int tv;
        int din;
        int dout;
        int found;
        int listed;
        n  = active_vertices();
        fv = req.from_vertex;
        tv = req.to_vertex;
        case (req.operation)
            OP_ADD_EDGE, OP_REMOVE_EDGE, OP_EDGE_TEST:
            begin
                if (!vertex_in_range(fv, n) || !vertex_in_range(tv, n))
                    push_expected(ST_RANGE, fv, 0, 0, 1'b0, 1'b1);
                else if (req.operation == OP_ADD_EDGE && graph_cells[fv-1][tv-1] != 16'h0)
                    push_expected(ST_PRESENT, fv, 0, 0, 1'b0, 1'b1);
                else
                begin
                    if (req.operation == OP_ADD_EDGE)
                        graph_cells[fv-1][tv-1] = req.edge_weight;
                    else if (req.operation == OP_REMOVE_EDGE)
                        graph_cells[fv-1][tv-1] = 16'h0;
                    push_expected(ST_OK, fv, 0, 0,
                                  req.operation == OP_EDGE_TEST &&
                                  graph_cells[fv-1][tv-1] != 16'h0, 1'b1);
                end
            end
            OP_DEGREE:
            begin
                if (!vertex_in_range(fv, n))
                    push_expected(ST_RANGE, fv, 0, 0, 1'b0, 1'b1);
                else
                begin
                    count_degrees(fv - 1, n, din, dout);
                    push_expected(ST_OK, fv, din, dout, 1'b0, 1'b1);
                end
            end
            OP_ALL_DEGREES:
            begin
                // with no vertex in use there is one out of range result about vertex 0
                if (n == 0)
                    push_expected(ST_RANGE, 0, 0, 0, 1'b0, 1'b1);
                for (int i = 0; i < n; i++)
                begin
                    count_degrees(i, n, din, dout);
                    push_expected(ST_OK, i + 1, din, dout, 1'b0, i == n - 1);
                end
            end
            OP_ADJ_LIST:
            begin
                if (!vertex_in_range(fv, n))
                    push_expected(ST_RANGE, fv, 0, 0, 1'b0, 1'b1);
                else
                begin
                    found = 0;
                    for (int i = 0; i < n; i++)
                        if (graph_cells[fv-1][i] != 16'h0)
                            found++;
                    if (found == 0)
                        push_expected(ST_NONE, fv, 0, 0, 1'b0, 1'b1);
                    listed = 0;
                    for (int i = 0; i < n; i++)
                        if (graph_cells[fv-1][i] != 16'h0)
                        begin
                            listed++;
                            push_expected(ST_OK, i + 1, 0, 0, 1'b0, listed == found);
                        end
                end
            end
            default:
                ; // reserved codes give no result
        endcase
    endtask

    // ------------------------------------------------------------------
    // request generation
    // ------------------------------------------------------------------

    function automatic item_t make_request(logic [2:0] op, logic [4:0] from_v,
                                           logic [4:0] to_v, logic [15:0] weight);
        item_t req;
        req.operation   = op;
        req.from_vertex = from_v;
        req.to_vertex   = to_v;
        req.edge_weight = weight;
        return req;
    endfunction

    // mostly vertices in use, now and then any 5-bit value
    function automatic logic [4:0] random_vertex(int n);
        if (n == 0 || $urandom_range(0, 9) == 0)
            return 5'($urandom_range(0, 31));
        return 5'($urandom_range(1, n));
    endfunction

    function automatic item_t random_request(int n);
        item_t req;
        int    pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            req.operation = OP_ADD_EDGE;
        else if (pick < 42)
            req.operation = OP_REMOVE_EDGE;
        else if (pick < 55)
            req.operation = OP_DEGREE;
        else if (pick < 60)
            req.operation = OP_ALL_DEGREES;
        else if (pick < 72)
            req.operation = OP_ADJ_LIST;
        else if (pick < 97)
            req.operation = OP_EDGE_TEST;
        else
            req.operation = pick[0] ? OP_RESERVED_A : OP_RESERVED_B;
        req.from_vertex = random_vertex(n);
        req.to_vertex   = random_vertex(n);
        pick = $urandom_range(0, 15);
        if (pick == 0)
            req.edge_weight = '0;
        else if (pick == 1)
            req.edge_weight = pick[0] ? 16'h8000 : 16'h7fff;
        else
            req.edge_weight = 16'($urandom);
        return req;
    endfunction

    task automatic queue_random_requests(int count);
        for (int i = 0; i < count; i++)
            pending_requests.push_back(random_request(active_vertices()));
    endtask

    // sender stays quiet until every owed result is back, then lets the
    // block finish whatever request produced no result
    task automatic wait_for_drain();
        do
            @(posedge clk);
        while (pending_requests.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_vertex_count(logic [4:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        shadow_vertex_count = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // request driver: changes at the falling edge, holds a request until taken
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || req_taken)
        begin
            if (tx_idle_left > 0)
            begin
                s_tvalid <= 1'b0;
                tx_idle_left--;
            end
            else if (idling_enabled && $urandom_range(0, 5) == 0)
            begin
                // idle burst; tx_idle_left holds the further idle cycles
                s_tvalid     <= 1'b0;
                tx_idle_left = $urandom_range(0, 16);
            end
            else if (pending_requests.size() != 0)
            begin
                s_tdata  <= {3'b000, pending_requests.pop_front()};
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result receiver: random stalls plus one long hold-off
    always @(negedge clk)
    begin
        if (!rst_n || rx_hold)
            m_tready <= 1'b0;
        else if (rx_idle_left > 0)
        begin
            m_tready <= 1'b0;
            rx_idle_left--;
        end
        else if (idling_enabled && $urandom_range(0, 5) == 0)
        begin
            m_tready     <= 1'b0;
            rx_idle_left = $urandom_range(0, 16);
        end
        else
            m_tready <= 1'b1;
    end

    // long hold-off in the middle of the busiest phase: the output register
    // fills, the block stops taking requests while the sender keeps offering
    initial
    begin
        wait (requests_taken >= 120);
        @(posedge clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
    end

    // ------------------------------------------------------------------
    // monitor: checks results against the oldest expectation, then predicts
    // the results of a request taken at the same edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t seen;
        result_t want;
        if (!rst_n)
            req_taken = 1'b0;
        else
        begin
            req_taken = s_tvalid && s_tready;
            if (m_tvalid && m_tready)
            begin
                seen = result_t'({m_tlast, m_tdata});
                if (expected_results.size() == 0)
                begin
                    $error("result with nothing expected: status %0d vertex %0d",
                           seen.status, seen.vertex_number);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (seen.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, seen.status);
                        mismatches++;
                    end
                    if (seen.vertex_number !== want.vertex_number)
                    begin
                        $error("vertex_number: expected %0d, actual %0d",
                               want.vertex_number, seen.vertex_number);
                        mismatches++;
                    end
                    if (seen.in_degree !== want.in_degree)
                    begin
                        $error("in_degree: expected %0d, actual %0d",
                               want.in_degree, seen.in_degree);
                        mismatches++;
                    end
                    if (seen.out_degree !== want.out_degree)
                    begin
                        $error("out_degree: expected %0d, actual %0d",
                               want.out_degree, seen.out_degree);
                        mismatches++;
                    end
                    if (seen.total_degree !== want.total_degree)
                    begin
                        $error("total_degree: expected %0d, actual %0d",
                               want.total_degree, seen.total_degree);
                        mismatches++;
                    end
                    if (seen.edge_present !== want.edge_present)
                    begin
                        $error("edge_present: expected %0d, actual %0d",
                               want.edge_present, seen.edge_present);
                        mismatches++;
                    end
                    if (seen.last_result !== want.last_result)
                    begin
                        $error("last_result: expected %0d, actual %0d",
                               want.last_result, seen.last_result);
                        mismatches++;
                    end
                end
            end
            if (req_taken)
            begin
                predict_graph_results(item_t'(s_tdata[28:0]));
                requests_taken++;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus phases
    // ------------------------------------------------------------------
    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed pass at the reset vertex count, matrix empty after clearing
        pending_requests.push_back(make_request(OP_ADD_EDGE, 5'd1, 5'd16, 16'h8000));
        pending_requests.push_back(make_request(OP_ADD_EDGE, 5'd16, 5'd1, 16'h7fff));
        // edge already there
        pending_requests.push_back(make_request(OP_ADD_EDGE, 5'd1, 5'd16, 16'h0005));
        // zero weight leaves the cell empty
        pending_requests.push_back(make_request(OP_ADD_EDGE, 5'd2, 5'd3, 16'h0000));
        pending_requests.push_back(make_request(OP_EDGE_TEST, 5'd2, 5'd3, 16'h0000));
        pending_requests.push_back(make_request(OP_EDGE_TEST, 5'd1, 5'd16, 16'hffff));
        // removing an empty cell
        pending_requests.push_back(make_request(OP_REMOVE_EDGE, 5'd2, 5'd3, 16'h0000));
        // self loop counts in both row and column
        pending_requests.push_back(make_request(OP_ADD_EDGE, 5'd1, 5'd1, 16'hffff));
        pending_requests.push_back(make_request(OP_DEGREE, 5'd1, 5'd0, 16'h0000));
        pending_requests.push_back(make_request(OP_DEGREE, 5'd16, 5'd31, 16'h0000));
        pending_requests.push_back(make_request(OP_ADJ_LIST, 5'd1, 5'd0, 16'h0000));
        // vertex with no neighbours
        pending_requests.push_back(make_request(OP_ADJ_LIST, 5'd5, 5'd0, 16'h0000));
        pending_requests.push_back(make_request(OP_ALL_DEGREES, 5'd0, 5'd0, 16'h0000));
        // vertices out of range on either side
        pending_requests.push_back(make_request(OP_ADD_EDGE, 5'd0, 5'd3, 16'h1234));
        pending_requests.push_back(make_request(OP_EDGE_TEST, 5'd3, 5'd17, 16'h0000));
        pending_requests.push_back(make_request(OP_DEGREE, 5'd31, 5'd1, 16'h0000));
        pending_requests.push_back(make_request(OP_ADJ_LIST, 5'd0, 5'd1, 16'h0000));
        pending_requests.push_back(make_request(OP_REMOVE_EDGE, 5'd31, 5'd0, 16'h0000));
        pending_requests.push_back(make_request(OP_REMOVE_EDGE, 5'd16, 5'd1, 16'h0000));
        pending_requests.push_back(make_request(OP_EDGE_TEST, 5'd16, 5'd1, 16'h0000));
        // reserved codes are dropped without a result
        pending_requests.push_back(make_request(OP_RESERVED_A, 5'd31, 5'd31, 16'hffff));
        pending_requests.push_back(make_request(OP_RESERVED_B, 5'd1, 5'd1, 16'h0001));
        pending_requests.push_back(make_request(OP_DEGREE, 5'd16, 5'd16, 16'h0000));
        wait_for_drain();

        // no vertex in use: everything out of range
        write_vertex_count(5'd0);
        pending_requests.push_back(make_request(OP_ALL_DEGREES, 5'd1, 5'd1, 16'h0000));
        queue_random_requests(15);
        wait_for_drain();

        // single vertex, only the self loop is reachable
        write_vertex_count(5'd1);
        queue_random_requests(20);
        wait_for_drain();

        // count above the matrix size saturates; main random phase with the hold-off
        write_vertex_count(5'd31);
        queue_random_requests(180);
        wait_for_drain();

        // shrunk graph: outer cells are kept but hidden, dense traffic on 25 cells
        write_vertex_count(5'd5);
        queue_random_requests(50);
        wait_for_drain();

        // back to full size with no idling on either side
        idling_enabled = 1'b0;
        write_vertex_count(5'd16);
        pending_requests.push_back(make_request(OP_ALL_DEGREES, 5'd16, 5'd16, 16'h0000));
        queue_random_requests(35);
        wait_for_drain();

        if (mismatches == 0 && expected_results.size() == 0)
            $display("weighted_adjacency_matrix_store test passed");
        else
            $display("weighted_adjacency_matrix_store test failed");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("weighted_adjacency_matrix_store test failed");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/wams_pkg.sv
hw/rtl/wams_matrix_mem.sv
hw/rtl/wams_ctrl.sv
hw/rtl/weighted_adjacency_matrix_store.sv
verif/tb_top.sv
